FILE: rtl/assert_macros.svh
// Assertion macros shared by the priority packet queue RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted.
`define PPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define PPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ppq_pkg.sv
// Package for the priority packet queue: status, operation and register codes,
// fixed field widths and the carry control type passed between queue cells.
// No dependencies.
`timescale 1ns / 1ps

package ppq_pkg;

    localparam int STATUS_W  = 3;
    localparam int BACKLOG_W = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [STATUS_W-1:0] ST_PUSHED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKLOG   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_PRIO = 1'b1;

    localparam logic [BACKLOG_W-1:0] BACKLOG_RESET = 5'd16;

    typedef struct packed {
        logic valid;
        logic found;   // insertion point passed, carry holds a displaced entry
        logic tail;    // droppable push, goes to the first free cell
    } ppq_carry_ctl_t;

endpackage

FILE: rtl/ppq_cell.sv
// One queue cell: holds an entry, shifts toward the head on pop and passes
// an insertion carry to the next cell. Depends on ppq_pkg.
`timescale 1ns / 1ps

module ppq_cell #(
    parameter int HANDLE_BITS   = 16,
    parameter int PRIORITY_BITS = 3
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     shift_en,
    input  logic                     right_valid,
    input  logic [HANDLE_BITS-1:0]   right_handle,
    input  logic [PRIORITY_BITS-1:0] right_prio,
    input  ppq_pkg::ppq_carry_ctl_t  in_ctl,
    input  logic [HANDLE_BITS-1:0]   in_handle,
    input  logic [PRIORITY_BITS-1:0] in_prio,
    output logic                     entry_valid,
    output logic [HANDLE_BITS-1:0]   entry_handle,
    output logic [PRIORITY_BITS-1:0] entry_prio,
    output ppq_pkg::ppq_carry_ctl_t  out_ctl,
    output logic [HANDLE_BITS-1:0]   out_handle,
    output logic [PRIORITY_BITS-1:0] out_prio
);
    import ppq_pkg::*;

    logic                     valid_reg, valid_next;
    logic [HANDLE_BITS-1:0]   handle_reg, handle_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    ppq_carry_ctl_t           ctl_reg, ctl_next;
    logic [HANDLE_BITS-1:0]   chandle_reg, chandle_next;
    logic [PRIORITY_BITS-1:0] cprio_reg, cprio_next;

    always_comb begin
        valid_next   = valid_reg;
        handle_next  = handle_reg;
        prio_next    = prio_reg;
        ctl_next     = '0;
        chandle_next = in_handle;
        cprio_next   = in_prio;
        if (shift_en) begin
            valid_next  = right_valid;
            handle_next = right_handle;
            prio_next   = right_prio;
        end else if (in_ctl.valid) begin
            if (!valid_reg) begin
                valid_next  = 1'b1;
                handle_next = in_handle;
                prio_next   = in_prio;
            end else if (in_ctl.found || (!in_ctl.tail && (prio_reg < in_prio))) begin
                handle_next    = in_handle;
                prio_next      = in_prio;
                ctl_next.valid = 1'b1;
                ctl_next.found = 1'b1;
                ctl_next.tail  = in_ctl.tail;
                chandle_next   = handle_reg;
                cprio_next     = prio_reg;
            end else begin
                ctl_next = in_ctl;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ctl_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            ctl_reg   <= ctl_next;
        end
        handle_reg  <= handle_next;
        prio_reg    <= prio_next;
        chandle_reg <= chandle_next;
        cprio_reg   <= cprio_next;
    end

    assign entry_valid  = valid_reg;
    assign entry_handle = handle_reg;
    assign entry_prio   = prio_reg;
    assign out_ctl      = ctl_reg;
    assign out_handle   = chandle_reg;
    assign out_prio     = cprio_reg;

endmodule

FILE: rtl/priority_packet_queue_unit.sv
// Top level of the priority packet queue: command decode, count, config
// registers, result register and the chain of ppq_cell instances.
// Depends on ppq_pkg, ppq_cell and assert_macros.svh.
//
//  channel | ports                     | contents
//  --------+---------------------------+-----------------------------------------
//  input   | s_tvalid/s_tready/s_tdata | tuser: operation; tdata: handle, priority
//  result  | m_tvalid/m_tready/m_tdata | tuser: status; tdata: handle, occupancy
//  config  | cfg_we/cfg_index/cfg_wdata| backlog (0), droppable priority (1)
//
// A pop, an ignored push and a rejected push start no carry. A push that lands walks
// an insertion carry down the cell chain one cell per cycle; the next item is taken
// only once that carry has come to rest in a free cell.
// The result is registered and shows in the cycle after the item is accepted.
// Reset is synchronous: count, cell valid bits and carries clear, backlog = 16.
// A stalled result holds; input is taken only with the chain idle and the
// result register empty or being drained.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module priority_packet_queue_unit #(
    parameter int DEPTH         = 16,
    parameter int HANDLE_BITS   = 16,
    parameter int PRIORITY_BITS = 3
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [HANDLE_BITS-1:0] packet_handle, then priority_req
    input  logic [((HANDLE_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_tdata,
    // [0] operation
    input  logic [0:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [HANDLE_BITS-1:0] handle_out, then occupancy
    output logic [((HANDLE_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // [2:0] status
    output logic [ppq_pkg::STATUS_W-1:0]           m_tuser,
    input  logic                                   cfg_we,
    input  logic [ppq_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [((PRIORITY_BITS > ppq_pkg::BACKLOG_W) ?
                   PRIORITY_BITS : ppq_pkg::BACKLOG_W)-1:0] cfg_wdata
);
    import ppq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > BACKLOG_W) ? CNT_W : BACKLOG_W;
    localparam int OUT_W = ((HANDLE_BITS + CNT_W + 7) / 8) * 8;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [BACKLOG_W-1:0]     backlog_reg;
    logic [PRIORITY_BITS-1:0] drop_prio_reg;
    logic                     m_valid_reg;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [HANDLE_BITS-1:0]   hout_reg, hout_next;
    logic [CNT_W-1:0]         occ_reg;

    logic                     cell_valid [DEPTH+1];
    logic [HANDLE_BITS-1:0]   cell_handle [DEPTH+1];
    logic [PRIORITY_BITS-1:0] cell_prio [DEPTH+1];
    ppq_carry_ctl_t           carry_ctl [DEPTH+1];
    logic [HANDLE_BITS-1:0]   carry_handle [DEPTH+1];
    logic [PRIORITY_BITS-1:0] carry_prio [DEPTH+1];
    logic [DEPTH-1:0]         valid_vec;
    logic [DEPTH:0]           carry_vec;

    logic                     busy;
    logic                     accept;
    logic                     op;
    logic [HANDLE_BITS-1:0]   in_handle;
    logic [PRIORITY_BITS-1:0] in_prio;
    logic                     is_drop;
    logic                     lands;
    logic                     shift_en;

    assign op        = s_tuser[0];
    assign in_handle = s_tdata[HANDLE_BITS-1:0];
    assign in_prio   = s_tdata[HANDLE_BITS+PRIORITY_BITS-1:HANDLE_BITS];
    assign is_drop   = (in_prio == drop_prio_reg);

    assign busy     = |carry_vec;
    assign s_tready = !busy && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        status_next = ST_PUSHED;
        hout_next   = '0;
        count_next  = count_reg;
        lands       = 1'b0;
        shift_en    = 1'b0;
        if (op == OP_POP) begin
            if (count_reg == '0) begin
                status_next = ST_EMPTY;
            end else begin
                status_next = ST_POPPED;
                hout_next   = cell_handle[0];
                count_next  = count_reg - CNT_W'(1);
                shift_en    = accept;
            end
        end else if (count_reg == '0) begin
            lands = 1'b1;
        end else if (is_drop && (CMP_W'(count_reg) >= CMP_W'(backlog_reg))) begin
            status_next = ST_IGNORED;
        end else if (count_reg == CNT_W'(DEPTH)) begin
            status_next = ST_FULL;
        end else begin
            lands = 1'b1;
        end
        if (lands) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign carry_ctl[0].valid = accept && lands;
    assign carry_ctl[0].found = 1'b0;
    assign carry_ctl[0].tail  = is_drop;
    assign carry_handle[0]    = in_handle;
    assign carry_prio[0]      = in_prio;

    assign cell_valid[DEPTH]  = 1'b0;
    assign cell_handle[DEPTH] = '0;
    assign cell_prio[DEPTH]   = '0;
    assign carry_vec[0]       = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        ppq_cell #(
            .HANDLE_BITS  (HANDLE_BITS),
            .PRIORITY_BITS(PRIORITY_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (shift_en),
            .right_valid (cell_valid[i+1]),
            .right_handle(cell_handle[i+1]),
            .right_prio  (cell_prio[i+1]),
            .in_ctl      (carry_ctl[i]),
            .in_handle   (carry_handle[i]),
            .in_prio     (carry_prio[i]),
            .entry_valid (cell_valid[i]),
            .entry_handle(cell_handle[i]),
            .entry_prio  (cell_prio[i]),
            .out_ctl     (carry_ctl[i+1]),
            .out_handle  (carry_handle[i+1]),
            .out_prio    (carry_prio[i+1])
        );
        assign valid_vec[i]   = cell_valid[i];
        assign carry_vec[i+1] = carry_ctl[i+1].valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            backlog_reg   <= BACKLOG_RESET;
            drop_prio_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BACKLOG:   backlog_reg   <= cfg_wdata[BACKLOG_W-1:0];
                    CFG_DROP_PRIO: drop_prio_reg <= cfg_wdata[PRIORITY_BITS-1:0];
                endcase
            end
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            status_reg <= status_next;
            hout_reg   <= hout_next;
            occ_reg    <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_W'({occ_reg, hout_reg});

    // only one insertion is ever in flight along the chain
    `PPQ_ASSERT(a_one_carry, aclk, aresetn, $onehot0(carry_vec), "more than one carry in flight")
    // at rest the count matches the occupied cells
    `PPQ_ASSERT(a_count_cells, aclk, aresetn, !busy |-> (DEPTH'(count_reg) == DEPTH'($countones(valid_vec))), "count does not match occupied cells")
    // at rest occupied cells form a run from the head
    `PPQ_ASSERT(a_packed, aclk, aresetn, !busy |-> ((valid_vec & (valid_vec + DEPTH'(1))) == '0), "gap in occupied cells")
    // a pop never overlaps a moving insertion
    `PPQ_ASSERT(a_pop_idle, aclk, aresetn, shift_en |-> !busy, "pop while insertion in flight")

endmodule
